// ===== rtl/dswg_pkg.sv =====
package dswg_pkg;

   // Field widths of the item channels and the configuration register.
   localparam int MODE_BITS     = 2;
   localparam int DIGIT_BITS    = 4;
   localparam int VALUE_BITS    = 14;
   localparam int OVERHEAD_BITS = 8;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 16;

   // Divider operands: the dividend is the half second in microseconds, the divisor the
   // entered value.
   localparam int DIV_BITS     = 19;
   localparam int DIVISOR_BITS = 14;

   // Four-thirds scaling of the first quotient q: floor(4q/3) equals
   // (q * THIRD_RECIP) >> SCALE_SHIFT, as THIRD_RECIP is 2^21/3 rounded up and 4q < 2^21.
   localparam int SCALED_BITS  = 20;
   localparam int RECIP_BITS   = 20;
   localparam int SCALE_SHIFT  = 19;
   localparam int PRODUCT_BITS = DIV_BITS + RECIP_BITS;

   localparam logic [DIV_BITS-1:0]      HALF_SECOND_US = 19'd500000;
   localparam logic [RECIP_BITS-1:0]    THIRD_RECIP    = 20'd699051;
   localparam logic [DIGIT_BITS-1:0]    DIGIT_MAX      = 4'd9;
   localparam logic [OVERHEAD_BITS-1:0] OVERHEAD_RESET = 8'd14;

   // Decimal weights of the three upper stored digits, most significant first.
   localparam logic [VALUE_BITS-1:0] WEIGHT_THOUSANDS = 14'd1000;
   localparam logic [VALUE_BITS-1:0] WEIGHT_HUNDREDS  = 14'd100;
   localparam logic [VALUE_BITS-1:0] WEIGHT_TENS      = 14'd10;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_TICK   = 2'd0,
      MODE_KEY    = 2'd1,
      MODE_BUTTON = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   // Update request from the sequencer to the digit store.
   typedef struct packed {
      logic                  shift;
      logic                  clear;
      logic [DIGIT_BITS-1:0] digit;
   } digit_ctrl_type;

endpackage

// ===== rtl/dswg_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module dswg_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [dswg_pkg::DIV_BITS-1:0]      dividend,
   input  logic [dswg_pkg::DIVISOR_BITS-1:0]  divisor,
   output logic                               done,
   output logic [dswg_pkg::DIV_BITS-1:0]      quotient
);

   localparam int STEP_BITS = $clog2(dswg_pkg::DIV_BITS + 1);

   logic [dswg_pkg::DIV_BITS-1:0]     quo_ff, quo_in;
   logic [dswg_pkg::DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [dswg_pkg::DIVISOR_BITS-1:0] div_ff, div_in;
   logic [STEP_BITS-1:0]              step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   logic [dswg_pkg::DIVISOR_BITS:0]   trial;
   logic [dswg_pkg::DIVISOR_BITS:0]   diff;
   logic                              fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial = {rem_ff, quo_ff[dswg_pkg::DIV_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_BITS'(dswg_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[dswg_pkg::DIV_BITS-2:0], fits};
         rem_in  = fits ? diff[dswg_pkg::DIVISOR_BITS-1:0]
                        : trial[dswg_pkg::DIVISOR_BITS-1:0];
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/dswg_digits.sv =====
// Four-digit decimal entry register and its binary value.
module dswg_digits (
   input  logic                               clock,
   input  logic                               reset,
   input  dswg_pkg::digit_ctrl_type           ctrl,
   output logic [dswg_pkg::VALUE_BITS-1:0]    value
);

   logic [dswg_pkg::DIGIT_BITS-1:0] digit_ff [4];
   logic [dswg_pkg::DIGIT_BITS-1:0] digit_in [4];

   // A key shifts toward the thousands place; a stop clears every digit.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         digit_in[i] = digit_ff[i];
      end
      if (ctrl.clear) begin
         for (int i = 0; i < 4; i++) begin
            digit_in[i] = '0;
         end
      end else if (ctrl.shift) begin
         digit_in[0] = digit_ff[1];
         digit_in[1] = digit_ff[2];
         digit_in[2] = digit_ff[3];
         digit_in[3] = ctrl.digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff[0] <= '0;
         digit_ff[1] <= '0;
         digit_ff[2] <= '0;
         digit_ff[3] <= dswg_pkg::DIGIT_BITS'(1);
      end else begin
         for (int i = 0; i < 4; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
   end

   // Weighted sum of the digits, thousands first.
   assign value =
        dswg_pkg::VALUE_BITS'(digit_ff[0]) * dswg_pkg::WEIGHT_THOUSANDS
      + dswg_pkg::VALUE_BITS'(digit_ff[1]) * dswg_pkg::WEIGHT_HUNDREDS
      + dswg_pkg::VALUE_BITS'(digit_ff[2]) * dswg_pkg::WEIGHT_TENS
      + dswg_pkg::VALUE_BITS'(digit_ff[3]);

endmodule

// ===== rtl/decimal_square_wave_generator_top.sv =====
// Square-wave generator set by four decimal digits of frequency in hertz. Each request item
// is a tick of the machine cycle, a key digit, or the start/stop button, and each one gives
// exactly one response item carrying the wave level, the running flag and the entered value
// as they stand after that item. Tick, key, stop and ignored items are committed from the
// execute state, when their response appears, and the next request item is taken once the
// sequencer is back in idle. A start runs 19 steps of a bit-serial divider for 500000/f,
// a reciprocal multiply that applies the 4/3 scaling, registered as the divider finishes,
// and a clamp state that subtracts the overhead register and clamps the result to the
// counter range, then commits in the apply state. A response that is not taken holds the
// next commit back, so receiver stalls lengthen these sequences. A new request item is
// accepted as soon as the previous one is committed, even while its response still waits.
module decimal_square_wave_generator_top #(
   parameter int COUNT_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request item: tdata = key_digit[3:0], then zero padding; tuser = mode[1:0].
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dswg_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [dswg_pkg::MODE_BITS-1:0]       req_tuser,
   // Response item: tdata = wave_level, running, entered_value[13:0].
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dswg_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Overhead cycle count subtracted from each half period.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dswg_pkg::OVERHEAD_BITS-1:0]   csr_data
);

   localparam int WIDE_BITS = (COUNT_BITS > dswg_pkg::SCALED_BITS) ? COUNT_BITS
                                                                   : dswg_pkg::SCALED_BITS;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_CLAMP  = 5'b01000,
      ST_APPLY  = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   dswg_pkg::mode_type                 mode_ff, mode_in;
   logic [dswg_pkg::DIGIT_BITS-1:0]    key_ff, key_in;
   logic [dswg_pkg::OVERHEAD_BITS-1:0] overhead_ff, overhead_in;
   logic                               running_ff, running_in;
   logic                               level_ff, level_in;
   logic [COUNT_BITS-1:0]              half_period_ff, half_period_in;
   logic [COUNT_BITS-1:0]              cycle_count_ff, cycle_count_in;
   logic [dswg_pkg::SCALED_BITS-1:0]   scaled_ff, scaled_in;
   logic [COUNT_BITS-1:0]              hp_calc_ff, hp_calc_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   dswg_pkg::digit_ctrl_type           digit_ctrl;
   logic [dswg_pkg::VALUE_BITS-1:0]    entered_value;

   logic                               div_start;
   logic                               div_done;
   logic [dswg_pkg::DIV_BITS-1:0]      div_dividend;
   logic [dswg_pkg::DIVISOR_BITS-1:0]  div_divisor;
   logic [dswg_pkg::DIV_BITS-1:0]      div_quotient;

   logic                               out_free;
   logic                               is_start;
   logic [COUNT_BITS-1:0]              count_next;
   logic [dswg_pkg::PRODUCT_BITS-1:0]  scale_product;
   logic [WIDE_BITS-1:0]               scaled_wide;
   logic [WIDE_BITS-1:0]               ovh_wide;
   logic [WIDE_BITS-1:0]               hp_sub;
   logic [WIDE_BITS-1:0]               count_max;

   dswg_digits u_digits (
      .clock (clock),
      .reset (reset),
      .ctrl  (digit_ctrl),
      .value (entered_value)
   );

   dswg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Handshakes and the response, which reflects the committed state.
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {entered_value, running_ff, level_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign is_start = (mode_ff == dswg_pkg::MODE_BUTTON) && !running_ff
                     && (entered_value != '0);

   // The divider finds the half second in microseconds divided by f.
   assign div_dividend = dswg_pkg::HALF_SECOND_US;
   assign div_divisor  = entered_value;

   // Four-thirds scaling of the quotient by a reciprocal multiply.
   assign scale_product = dswg_pkg::PRODUCT_BITS'(div_quotient)
                          * dswg_pkg::PRODUCT_BITS'(dswg_pkg::THIRD_RECIP);
   assign scaled_in     = scale_product[dswg_pkg::SCALE_SHIFT +: dswg_pkg::SCALED_BITS];

   // Overhead subtraction with a floor of one and a ceiling of the counter range.
   assign scaled_wide = WIDE_BITS'(scaled_ff);
   assign ovh_wide    = WIDE_BITS'(overhead_ff);
   assign count_max   = WIDE_BITS'({COUNT_BITS{1'b1}});
   assign hp_sub      = (scaled_wide > ovh_wide + WIDE_BITS'(1)) ? scaled_wide - ovh_wide
                                                                 : WIDE_BITS'(1);
   assign hp_calc_in  = (hp_sub > count_max) ? count_max[COUNT_BITS-1:0]
                                             : hp_sub[COUNT_BITS-1:0];

   assign count_next  = cycle_count_ff + COUNT_BITS'(1);
   assign overhead_in = (csr_valid && csr_ready) ? csr_data : overhead_ff;

   // Sequencer: latch the item, run the divider for a start, commit when the output is free.
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      key_in         = key_ff;
      running_in     = running_ff;
      level_in       = level_ff;
      half_period_in = half_period_ff;
      cycle_count_in = cycle_count_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      div_start      = 1'b0;
      digit_ctrl     = '{shift: 1'b0, clear: 1'b0, digit: key_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = dswg_pkg::mode_type'(req_tuser);
               key_in   = req_tdata[dswg_pkg::DIGIT_BITS-1:0];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (is_start) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               unique case (mode_ff)
                  dswg_pkg::MODE_TICK: begin
                     if (running_ff) begin
                        if (count_next >= half_period_ff) begin
                           level_in       = !level_ff;
                           cycle_count_in = '0;
                        end else begin
                           cycle_count_in = count_next;
                        end
                     end
                  end
                  dswg_pkg::MODE_KEY: begin
                     digit_ctrl.shift = (key_ff <= dswg_pkg::DIGIT_MAX);
                  end
                  dswg_pkg::MODE_BUTTON: begin
                     // Stop; a start with a zero value falls here and changes nothing.
                     if (running_ff) begin
                        running_in       = 1'b0;
                        level_in         = 1'b0;
                        cycle_count_in   = '0;
                        digit_ctrl.clear = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               half_period_in = hp_calc_ff;
               cycle_count_in = '0;
               running_in     = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         overhead_ff    <= dswg_pkg::OVERHEAD_RESET;
         running_ff     <= 1'b0;
         level_ff       <= 1'b0;
         half_period_ff <= '0;
         cycle_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         overhead_ff    <= overhead_in;
         running_ff     <= running_in;
         level_ff       <= level_in;
         half_period_ff <= half_period_in;
         cycle_count_ff <= cycle_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Item payload and the half period pipeline hold no control meaning.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      key_ff  <= key_in;
      if ((state_ff == ST_DIVIDE) && div_done) begin
         scaled_ff <= scaled_in;
      end
      if (state_ff == ST_CLAMP) begin
         hp_calc_ff <= hp_calc_in;
      end
   end

endmodule

// ===== verif/decimal_square_wave_generator_top_tb.sv =====
module decimal_square_wave_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_BITS     = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int RANDOM_ITEMS   = 450;
   localparam int PRINT_LIMIT    = 30;

   // Kinds of entries in the stimulus queue.
   typedef enum logic [1:0] {
      OP_ITEM,
      OP_CSR_WRITE,
      OP_DRAIN,
      OP_IDLING
   } op_kind_type;

   typedef struct {
      op_kind_type                        kind;
      dswg_pkg::mode_type                 mode;
      logic [dswg_pkg::DIGIT_BITS-1:0]    digit;
      logic [dswg_pkg::OVERHEAD_BITS-1:0] overhead;
      int                                 send_idle_pct;
      int                                 recv_stall_pct;
   } pending_op_type;

   // Layout of one response item, lowest bit last.
   typedef struct packed {
      logic [dswg_pkg::VALUE_BITS-1:0] value;
      logic                            running;
      logic                            level;
   } wave_status_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [dswg_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [dswg_pkg::MODE_BITS-1:0]     req_tuser  = dswg_pkg::MODE_NOP;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [dswg_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [dswg_pkg::OVERHEAD_BITS-1:0] csr_data   = '0;

   pending_op_type  pending_ops[$];
   wave_status_type expected_wave[$];

   // Predicted state of the generator.
   logic [dswg_pkg::DIGIT_BITS-1:0]    digit_reg [4];
   logic                               wave_running;
   logic                               wave_level;
   logic [COUNT_BITS-1:0]              half_period;
   logic [COUNT_BITS-1:0]              cycle_count;
   logic [dswg_pkg::OVERHEAD_BITS-1:0] overhead_reg;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_queued   = 0;
   int items_sent     = 0;
   int checked        = 0;
   int mismatches     = 0;
   int starts         = 0;
   int stops          = 0;
   int toggles        = 0;
   int csr_writes     = 0;
   int quiet_cycles   = 0;

   decimal_square_wave_generator_top #(
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned entered_hz();
      return digit_reg[0] * 1000 + digit_reg[1] * 100 + digit_reg[2] * 10 + digit_reg[3];
   endfunction

   // Advances the predicted state by one request item and queues the response it gives.
   function automatic void predict_step(dswg_pkg::mode_type mode,
                                        logic [dswg_pkg::DIGIT_BITS-1:0] digit);
      int unsigned     freq;
      longint unsigned period;
      wave_status_type status;
      case (mode)
         dswg_pkg::MODE_TICK: begin
            if (wave_running) begin
               cycle_count = cycle_count + 1'b1;
               if (cycle_count >= half_period) begin
                  wave_level  = ~wave_level;
                  cycle_count = '0;
                  toggles++;
               end
            end
         end
         dswg_pkg::MODE_KEY: begin
            // Out-of-range digits leave the store alone.
            if (digit <= dswg_pkg::DIGIT_MAX) begin
               digit_reg[0] = digit_reg[1];
               digit_reg[1] = digit_reg[2];
               digit_reg[2] = digit_reg[3];
               digit_reg[3] = digit;
            end
         end
         dswg_pkg::MODE_BUTTON: begin
            if (wave_running) begin
               wave_running = 1'b0;
               wave_level   = 1'b0;
               cycle_count  = '0;
               for (int i = 0; i < 4; i++) digit_reg[i] = '0;
               stops++;
            end else begin
               freq = entered_hz();
               // A zero frequency cannot start the wave.
               if (freq != 0) begin
                  // The machine cycle is 0.75 us, so scale the microsecond count by 4/3.
                  period = ((longint'(dswg_pkg::HALF_SECOND_US) / freq) * 4) / 3;
                  if (period > longint'(overhead_reg) + 1) begin
                     period = period - overhead_reg;
                  end else begin
                     period = 1;
                  end
                  if (period > (64'd1 << COUNT_BITS) - 1) begin
                     period = (64'd1 << COUNT_BITS) - 1;
                  end
                  half_period  = period[COUNT_BITS-1:0];
                  cycle_count  = '0;
                  wave_running = 1'b1;
                  starts++;
               end
            end
         end
         default: ;
      endcase
      status.level   = wave_level;
      status.running = wave_running;
      status.value   = entered_hz();
      expected_wave.push_back(status);
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("%0t ns: response %0d, %s: got %0d, expected %0d",
                  $realtime, checked, field, got, want);
      end
   endtask

   function automatic void add_item(dswg_pkg::mode_type mode, int unsigned digit);
      pending_op_type op;
      op.kind     = OP_ITEM;
      op.mode     = mode;
      op.digit    = digit[dswg_pkg::DIGIT_BITS-1:0];
      op.overhead = '0;
      pending_ops.push_back(op);
      items_queued++;
   endfunction

   function automatic void add_csr_write(int unsigned overhead);
      pending_op_type op;
      op.kind     = OP_CSR_WRITE;
      op.mode     = dswg_pkg::MODE_NOP;
      op.digit    = '0;
      op.overhead = overhead[dswg_pkg::OVERHEAD_BITS-1:0];
      pending_ops.push_back(op);
   endfunction

   function automatic void add_drain();
      pending_op_type op;
      op.kind     = OP_DRAIN;
      op.mode     = dswg_pkg::MODE_NOP;
      op.digit    = '0;
      op.overhead = '0;
      pending_ops.push_back(op);
   endfunction

   function automatic void add_idling(int send_pct, int recv_pct);
      pending_op_type op;
      op.kind           = OP_IDLING;
      op.mode           = dswg_pkg::MODE_NOP;
      op.digit          = '0;
      op.overhead       = '0;
      op.send_idle_pct  = send_pct;
      op.recv_stall_pct = recv_pct;
      pending_ops.push_back(op);
   endfunction

   function automatic void add_noise();
      add_item(dswg_pkg::mode_type'($urandom_range(3)), $urandom_range(15));
   endfunction

   // One usage session: enter four digits, start, run ticks, usually stop again. The tick
   // run is shortened so the session stays close to the remaining item budget.
   function automatic void add_session(int budget);
      int ticks;
      int lead;
      lead = ($urandom_range(99) < 70) ? $urandom_range(9, 5) : $urandom_range(9);
      add_item(dswg_pkg::MODE_KEY, lead);
      repeat (3) add_item(dswg_pkg::MODE_KEY, $urandom_range(9));
      if ($urandom_range(9) == 0) add_noise();
      add_item(dswg_pkg::MODE_BUTTON, $urandom_range(15));
      ticks = $urandom_range(90, 4);
      if (ticks > budget - 6) begin
         ticks = (budget > 10) ? budget - 6 : 4;
      end
      repeat (ticks) begin
         if ($urandom_range(99) < 8) begin
            add_noise();
         end else begin
            add_item(dswg_pkg::MODE_TICK, $urandom_range(15));
         end
      end
      if ($urandom_range(9) != 0) add_item(dswg_pkg::MODE_BUTTON, $urandom_range(15));
   endfunction

   // Driver: presents queued items and register writes, and feeds the predictor on acceptance.
   always @(posedge clock) begin
      pending_op_type head;
      logic           send_req;
      logic           send_csr;
      logic           busy;
      logic           done;
      if (reset) begin
         req_tvalid   <= 1'b0;
         csr_valid    <= 1'b0;
         digit_reg    = '{4'd0, 4'd0, 4'd0, 4'd1};
         wave_running = 1'b0;
         wave_level   = 1'b0;
         half_period  = '0;
         cycle_count  = '0;
         overhead_reg = dswg_pkg::OVERHEAD_RESET;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_step(dswg_pkg::mode_type'(req_tuser),
                         req_tdata[dswg_pkg::DIGIT_BITS-1:0]);
            items_sent++;
         end
         if (csr_valid && csr_ready) begin
            overhead_reg = csr_data;
            csr_writes++;
         end
         busy = (req_tvalid && !req_tready) || (csr_valid && !csr_ready);
         if (!busy) begin
            send_req = 1'b0;
            send_csr = 1'b0;
            done     = 1'b0;
            while (!done && pending_ops.size() > 0) begin
               head = pending_ops[0];
               case (head.kind)
                  OP_IDLING: begin
                     send_idle_pct  = head.send_idle_pct;
                     recv_stall_pct = head.recv_stall_pct;
                     void'(pending_ops.pop_front());
                  end
                  OP_DRAIN: begin
                     if (expected_wave.size() == 0) begin
                        void'(pending_ops.pop_front());
                     end else begin
                        done = 1'b1;
                     end
                  end
                  OP_CSR_WRITE: begin
                     // The register is only written once every response has come back.
                     done = 1'b1;
                     if (expected_wave.size() == 0) begin
                        send_csr = 1'b1;
                        csr_data <= head.overhead;
                        void'(pending_ops.pop_front());
                     end
                  end
                  default: begin
                     done = 1'b1;
                     if ($urandom_range(99) >= send_idle_pct) begin
                        send_req = 1'b1;
                        req_tdata <= dswg_pkg::REQ_DATA_BITS'(head.digit);
                        req_tuser <= head.mode;
                        void'(pending_ops.pop_front());
                     end
                  end
               endcase
            end
            req_tvalid <= send_req;
            csr_valid  <= send_csr;
         end
      end
   end

   // Monitor: throttles the response side and checks each response item against the oldest
   // prediction.
   always @(posedge clock) begin
      wave_status_type got;
      wave_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_wave.size() == 0) begin
               report_mismatch("unexpected item", got, '0);
            end else begin
               want = expected_wave.pop_front();
               checked++;
               if (got.level !== want.level) begin
                  report_mismatch("wave_level", got.level, want.level);
               end
               if (got.running !== want.running) begin
                  report_mismatch("running", got.running, want.running);
               end
               if (got.value !== want.value) begin
                  report_mismatch("entered_value", got.value, want.value);
               end
            end
         end
      end
   end

   // Watchdog: ends the run if no handshake completes for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d responses outstanding",
                  $realtime, WATCHDOG_LIMIT, expected_wave.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int target;

      // Directed part at reset overhead: ignored inputs, start at 1 Hz, key entry while
      // running, stop, start with a zero value, then a short half period.
      add_idling(0, 0);
      add_item(dswg_pkg::MODE_NOP, 15);
      add_item(dswg_pkg::MODE_KEY, 12);
      add_item(dswg_pkg::MODE_TICK, 0);
      add_item(dswg_pkg::MODE_BUTTON, 0);
      add_item(dswg_pkg::MODE_TICK, 15);
      add_item(dswg_pkg::MODE_KEY, 5);
      add_item(dswg_pkg::MODE_BUTTON, 3);
      add_item(dswg_pkg::MODE_BUTTON, 0);
      repeat (4) add_item(dswg_pkg::MODE_KEY, 9);
      add_item(dswg_pkg::MODE_KEY, 10);
      add_item(dswg_pkg::MODE_BUTTON, 0);
      add_item(dswg_pkg::MODE_TICK, 0);
      add_item(dswg_pkg::MODE_BUTTON, 0);

      // Largest overhead clamps the half period to one tick, so every tick toggles.
      add_csr_write(255);
      add_item(dswg_pkg::MODE_KEY, 8);
      add_item(dswg_pkg::MODE_KEY, 9);
      add_item(dswg_pkg::MODE_KEY, 15);
      add_item(dswg_pkg::MODE_KEY, 0);
      add_item(dswg_pkg::MODE_KEY, 0);
      add_item(dswg_pkg::MODE_BUTTON, 0);
      repeat (3) add_item(dswg_pkg::MODE_TICK, 0);
      add_item(dswg_pkg::MODE_BUTTON, 0);

      // Random phases under several overhead values and idling patterns.
      add_csr_write(0);
      target = items_queued + RANDOM_ITEMS / 4;
      while (items_queued < target) add_session(target - items_queued);

      add_csr_write(255);
      add_idling(61, 0);
      target = items_queued + RANDOM_ITEMS / 8;
      while (items_queued < target) add_session(target - items_queued);
      add_drain();
      target = items_queued + RANDOM_ITEMS / 8;
      while (items_queued < target) add_session(target - items_queued);

      add_csr_write($urandom_range(255));
      add_idling(0, 61);
      target = items_queued + RANDOM_ITEMS / 4;
      while (items_queued < target) add_session(target - items_queued);

      add_csr_write($urandom_range(60));
      add_idling(28, 28);
      target = items_queued + RANDOM_ITEMS / 4;
      while (items_queued < target) add_session(target - items_queued);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_ops.size() == 0 && items_sent == items_queued &&
            expected_wave.size() == 0 && !csr_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request items and checked %0d responses over %0d overhead writes.",
               items_sent, checked, csr_writes);
      $display("The wave started %0d times, stopped %0d times and toggled %0d times.",
               starts, stops, toggles);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
